FILE: hdl/cds_pkg.sv
// shared types, constants and calendar tables for the calendar date stepper
`timescale 1ns / 1ps
`default_nettype none

package cds_pkg;

    localparam int MAX_YEAR  = 9999;
    localparam int ADD_WIDTH = 16;

    // day-count bits taken from add_count, and the working day width that holds day + count
    localparam int CNT_W = (ADD_WIDTH < 16) ? ADD_WIDTH : 16;
    localparam int WD_W  = ((CNT_W > 5) ? CNT_W : 5) + 1;

    // year kept split as century and year within century
    localparam int Q_W = 8;
    localparam int R_W = 7;

    // y * 5243 >> 19 is y / 100 rounded down for every 14-bit year
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          RECIP_SH  = 19;

    localparam logic [13:0]    MAX_YEAR_W = 14'(MAX_YEAR);
    localparam logic [13:0]    CENT_DIV   = 14'd100;
    localparam logic [R_W-1:0] YREM_LAST  = 7'd99;
    localparam logic [3:0]     LAST_MONTH = 4'd12;
    localparam logic [4:0]     LAST_DAY   = 5'd31;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_NEXT = 2'd1;
    localparam logic [1:0] MODE_PREV = 2'd2;
    localparam logic [1:0] MODE_ADD  = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [4:0]  in_day;
        logic [3:0]  in_month;
        logic [13:0] in_year;
        logic [15:0] add_count;
    } cds_req_t;

    typedef struct packed {
        logic [4:0]  cur_day;
        logic [3:0]  cur_month;
        logic [13:0] cur_year;
        logic [2:0]  weekday;
        logic        error;
    } cds_rsp_t;

    typedef struct packed {
        logic [4:0]     day;
        logic [3:0]     month;
        logic [13:0]    year;
        logic [Q_W-1:0] cent;
        logic [R_W-1:0] yrem;
    } cds_date_t;

    // 4/100/400 rule; year % 4 equals yrem % 4 since a century is a multiple of four
    function automatic logic is_leap(input logic [Q_W-1:0] cent, input logic [R_W-1:0] yrem);
        return (yrem[1:0] == 2'd0) && ((yrem != '0) || (cent[1:0] == 2'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // 2m + 3(m+1)/5 mod 7, with january and february counted as months 13 and 14
    function automatic logic [2:0] month_term(input logic [3:0] m);
        logic [2:0] t;
        case (m)
            4'd1:    t = 3'd6;
            4'd2:    t = 3'd2;
            4'd3:    t = 3'd1;
            4'd4:    t = 3'd4;
            4'd5:    t = 3'd6;
            4'd6:    t = 3'd2;
            4'd7:    t = 3'd4;
            4'd8:    t = 3'd0;
            4'd9:    t = 3'd3;
            4'd10:   t = 3'd5;
            4'd11:   t = 3'd1;
            4'd12:   t = 3'd3;
            default: t = 3'd0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/calendar_date_stepper.sv
// top level: date registers, step sequencer and result register
`timescale 1ns / 1ps
`default_nettype none

// Gregorian date stepper. Each request loads a date, steps one day forward or back, or adds
// up to 2^16-1 days; each request gives exactly one response with the stored date, its
// weekday (0 Monday .. 6 Sunday) and an error flag. The block takes one request at a time:
// req_ready is high only while it is idle, and a finished response waits in an output
// register, so a new request can be taken while that response is still pending. A next
// or previous day request passes the step state, a load first the reciprocal multiply that
// splits the year into century and remainder and then the range check, and an add stays in
// the add state until its days fit the month: one shared compare and subtract unit takes
// off one month length per cycle. Every request then passes the weekday start and wait
// states and the output state. Response back-pressure stalls the block before it becomes
// ready again.
module calendar_date_stepper
    import cds_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire cds_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output cds_rsp_t      rsp
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV    = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_STEP   = 3'd3;
    localparam logic [2:0] S_ADD    = 3'd4;
    localparam logic [2:0] S_WSTART = 3'd5;
    localparam logic [2:0] S_WWAIT  = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0]      state_reg,  state_next;
    logic [1:0]      mode_reg,   mode_next;
    logic [4:0]      day_reg,    day_next;
    logic [3:0]      month_reg,  month_next;
    logic [13:0]     year_reg,   year_next;
    logic [Q_W-1:0]  cent_reg,   cent_next;
    logic [R_W-1:0]  yrem_reg,   yrem_next;
    logic [WD_W-1:0] wd_reg,     wd_next;
    logic [3:0]      wm_reg,     wm_next;
    logic [13:0]     wy_reg,     wy_next;
    logic [Q_W-1:0]  wq_reg,     wq_next;
    logic [R_W-1:0]  wr_reg,     wr_next;
    logic [13:0]     rem_reg,    rem_next;
    logic            err_reg,    err_next;
    logic            out_valid_reg, out_valid_next;
    cds_rsp_t        out_reg,    out_next;

    logic        accept;
    logic        wday_start;
    logic        wday_done;
    logic [2:0]  wday;
    cds_date_t   cur_date;

    logic [26:0]    div_prod;
    logic [Q_W-1:0] div_q;
    logic [4:0]     chk_len;
    logic [4:0]     cur_len;
    logic [4:0]     prev_len;
    logic [4:0]     add_len;
    logic [R_W-1:0] yrem_inc,  yrem_dec, wr_inc;
    logic [Q_W-1:0] cent_inc,  cent_dec, wq_inc;

    assign accept = req_valid && req_ready;

    assign div_prod = 27'(rem_reg) * 27'(RECIP_100);
    assign div_q    = div_prod[RECIP_SH +: Q_W];

    assign chk_len  = month_len(wm_reg, is_leap(wq_reg, rem_reg[R_W-1:0]));
    assign cur_len  = month_len(month_reg, is_leap(cent_reg, yrem_reg));
    assign prev_len = month_len(4'(month_reg - 4'd1), is_leap(cent_reg, yrem_reg));
    assign add_len  = month_len(wm_reg, is_leap(wq_reg, wr_reg));

    assign yrem_inc = (yrem_reg == YREM_LAST) ? '0 : R_W'(yrem_reg + 1'b1);
    assign cent_inc = (yrem_reg == YREM_LAST) ? Q_W'(cent_reg + 1'b1) : cent_reg;
    assign yrem_dec = (yrem_reg == '0) ? YREM_LAST : R_W'(yrem_reg - 1'b1);
    assign cent_dec = (yrem_reg == '0) ? Q_W'(cent_reg - 1'b1) : cent_reg;
    assign wr_inc   = (wr_reg == YREM_LAST) ? '0 : R_W'(wr_reg + 1'b1);
    assign wq_inc   = (wr_reg == YREM_LAST) ? Q_W'(wq_reg + 1'b1) : wq_reg;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        cent_next      = cent_reg;
        yrem_next      = yrem_reg;
        wd_next        = wd_reg;
        wm_next        = wm_reg;
        wy_next        = wy_reg;
        wq_next        = wq_reg;
        wr_next        = wr_reg;
        rem_next       = rem_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        wday_start     = 1'b0;

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next    = req.mode;
                    err_next     = 1'b0;
                    wm_next      = month_reg;
                    wy_next      = year_reg;
                    wq_next      = cent_reg;
                    wr_next      = yrem_reg;
                    rem_next     = req.in_year;
                    wd_next      = WD_W'(day_reg) + WD_W'(req.add_count[CNT_W-1:0]);
                    case (req.mode)
                        MODE_LOAD:
                        begin
                            wd_next    = WD_W'(req.in_day);
                            wm_next    = req.in_month;
                            wy_next    = req.in_year;
                            wq_next    = '0;
                            state_next = S_DIV;
                        end
                        MODE_ADD:
                        begin
                            state_next = S_ADD;
                        end
                        default:
                        begin
                            state_next = S_STEP;
                        end
                    endcase
                end
            end

            // reciprocal multiply splits the load year into century and year within century
            S_DIV:
            begin
                wq_next    = div_q;
                rem_next   = rem_reg - 14'(14'(div_q) * CENT_DIV);
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if ((wy_reg != 14'd0) && (wy_reg <= MAX_YEAR_W) && (wd_reg != '0)
                    && (wd_reg <= WD_W'(chk_len)))
                begin
                    day_next   = wd_reg[4:0];
                    month_next = wm_reg;
                    year_next  = wy_reg;
                    cent_next  = wq_reg;
                    yrem_next  = rem_reg[R_W-1:0];
                end
                else
                begin
                    day_next   = 5'd1;
                    month_next = 4'd1;
                    year_next  = 14'd1;
                    cent_next  = '0;
                    yrem_next  = R_W'(1);
                    err_next   = 1'b1;
                end
                state_next = S_WSTART;
            end

            S_STEP:
            begin
                if (mode_reg == MODE_NEXT)
                begin
                    if (day_reg < cur_len)
                    begin
                        day_next = day_reg + 5'd1;
                    end
                    else if (month_reg < LAST_MONTH)
                    begin
                        day_next   = 5'd1;
                        month_next = month_reg + 4'd1;
                    end
                    else if (year_reg < MAX_YEAR_W)
                    begin
                        day_next   = 5'd1;
                        month_next = 4'd1;
                        year_next  = year_reg + 14'd1;
                        cent_next  = cent_inc;
                        yrem_next  = yrem_inc;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                else
                begin
                    if (day_reg > 5'd1)
                    begin
                        day_next = day_reg - 5'd1;
                    end
                    else if (month_reg > 4'd1)
                    begin
                        month_next = month_reg - 4'd1;
                        day_next   = prev_len;
                    end
                    else if (year_reg > 14'd1)
                    begin
                        day_next   = LAST_DAY;
                        month_next = LAST_MONTH;
                        year_next  = year_reg - 14'd1;
                        cent_next  = cent_dec;
                        yrem_next  = yrem_dec;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                state_next = S_WSTART;
            end

            // one month length taken off per cycle
            S_ADD:
            begin
                if (wd_reg <= WD_W'(add_len))
                begin
                    day_next   = wd_reg[4:0];
                    month_next = wm_reg;
                    year_next  = wy_reg;
                    cent_next  = wq_reg;
                    yrem_next  = wr_reg;
                    state_next = S_WSTART;
                end
                else
                begin
                    wd_next = wd_reg - WD_W'(add_len);
                    if (wm_reg < LAST_MONTH)
                    begin
                        wm_next = wm_reg + 4'd1;
                    end
                    else if (wy_reg < MAX_YEAR_W)
                    begin
                        wm_next = 4'd1;
                        wy_next = wy_reg + 14'd1;
                        wq_next = wq_inc;
                        wr_next = wr_inc;
                    end
                    else
                    begin
                        // stored date left as it was
                        err_next   = 1'b1;
                        state_next = S_WSTART;
                    end
                end
            end

            S_WSTART:
            begin
                wday_start = 1'b1;
                state_next = S_WWAIT;
            end

            S_WWAIT:
            begin
                if (wday_done)
                begin
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next    = 1'b1;
                    out_next.cur_day   = day_reg;
                    out_next.cur_month = month_reg;
                    out_next.cur_year  = year_reg;
                    out_next.weekday   = wday;
                    out_next.error     = err_reg;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            day_reg       <= 5'd1;
            month_reg     <= 4'd1;
            year_reg      <= 14'd1;
            cent_reg      <= '0;
            yrem_reg      <= R_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            cent_reg      <= cent_next;
            yrem_reg      <= yrem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        wd_reg      <= wd_next;
        wm_reg      <= wm_next;
        wy_reg      <= wy_next;
        wq_reg      <= wq_next;
        wr_reg      <= wr_next;
        rem_reg     <= rem_next;
        err_reg     <= err_next;
        out_reg     <= out_next;
    end

    assign cur_date.day   = day_reg;
    assign cur_date.month = month_reg;
    assign cur_date.year  = year_reg;
    assign cur_date.cent  = cent_reg;
    assign cur_date.yrem  = yrem_reg;

    cds_weekday u_weekday (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (wday_start),
        .date    (cur_date),
        .done    (wday_done),
        .weekday (wday)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

FILE: hdl/cds_weekday.sv
// two-stage weekday unit: weighted sum of the date terms, then reduction mod 7
`timescale 1ns / 1ps
`default_nettype none

module cds_weekday
    import cds_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire cds_date_t date,
    output logic           done,
    output logic [2:0]     weekday
);

    logic        early;
    logic [13:0] y_adj;
    logic [Q_W-1:0] q_adj;
    logic [15:0] sum_next;
    logic [15:0] sum_reg;
    logic        s1_reg;
    logic        done_reg;
    logic [2:0]  wday_reg;
    logic [5:0]  fold1;
    logic [3:0]  fold2;
    logic [2:0]  fold3;
    logic [2:0]  wday_next;

    // january and february belong to the previous year
    assign early = (date.month <= 4'd2);
    assign y_adj = early ? 14'(date.year - 14'd1) : date.year;
    assign q_adj = (early && (date.yrem == '0)) ? Q_W'(date.cent - 1'b1) : date.cent;

    assign sum_next = 16'(date.day) + 16'(month_term(date.month)) + 16'(y_adj)
                    + 16'(y_adj >> 2) + 16'(q_adj >> 2) - 16'(q_adj);

    // 8 is 1 mod 7, so octal digits can be summed
    assign fold1 = 6'(sum_reg[2:0]) + 6'(sum_reg[5:3]) + 6'(sum_reg[8:6])
                 + 6'(sum_reg[11:9]) + 6'(sum_reg[14:12]) + 6'(sum_reg[15]);
    assign fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    assign fold3 = fold2[2:0] + 3'(fold2[3]);
    assign wday_next = (fold3 == 3'd7) ? 3'd0 : fold3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= start;
            done_reg <= s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sum_reg <= sum_next;
        end
        if (s1_reg)
        begin
            wday_reg <= wday_next;
        end
    end

    assign done    = done_reg;
    assign weekday = wday_reg;

endmodule

`default_nettype wire

FILE: hdl/cds_checker.sv
// port-level checks for the calendar date stepper, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module cds_checker
    import cds_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     req_valid,
    input wire logic     req_ready,
    input wire logic     rsp_valid,
    input wire logic     rsp_ready,
    input wire cds_rsp_t rsp
);

    // a stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed or dropped while stalled");

    // one request in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready after a request transfer");

    // a fresh response only ever comes as the block finishes its request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $rose(req_ready))
        else $error("response without a finishing request");

    // a valid response carries a weekday, month and year in range and a nonzero day
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.weekday <= 3'd6) && (rsp.cur_day != 5'd0)
            && (rsp.cur_month != 4'd0) && (rsp.cur_month <= LAST_MONTH)
            && (rsp.cur_year != 14'd0) && (rsp.cur_year <= MAX_YEAR_W))
        else $error("response date out of range");

endmodule

bind calendar_date_stepper cds_checker u_cds_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

FILE: dv/tb.sv
// testbench for the calendar date stepper: directed and random date steps checked against a predictor
`timescale 1ns / 1ps

module tb;
    import cds_pkg::*;

    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int DRAIN_CYCLES = 40;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    cds_req_t req;
    logic     rsp_valid;
    logic     rsp_ready;
    cds_rsp_t rsp;

    // predicted stored date
    int cal_day;
    int cal_month;
    int cal_year;

    cds_rsp_t pending_dates[$];
    int       mismatches  = 0;
    int       cycle_count = 0;
    int       send_idle   = 0;
    int       recv_idle   = 0;

    calendar_date_stepper u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in_month(input int m, input int y);
        int len;
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = leap_year(y) ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    function automatic int day_of_week(input int d, input int m, input int y);
        int mm;
        int yy;
        mm = m;
        yy = y;
        // january and february count as months 13 and 14 of the year before
        if (mm <= 2)
        begin
            mm = mm + 12;
            yy = yy - 1;
        end
        return (d + 2 * mm + 3 * (mm + 1) / 5 + yy + yy / 4 - yy / 100 + yy / 400) % 7;
    endfunction

    // applies one request to the predicted date and queues the response it should give
    function automatic void advance_date(input cds_req_t item);
        int       d;
        int       m;
        int       y;
        int       len;
        bit       err;
        cds_rsp_t res;
        d   = cal_day;
        m   = cal_month;
        y   = cal_year;
        err = 1'b0;
        case (item.mode)
            MODE_LOAD:
            begin
                if (item.in_year >= 1 && item.in_year <= MAX_YEAR && item.in_day >= 1
                    && item.in_day <= days_in_month(item.in_month, item.in_year))
                begin
                    d = item.in_day;
                    m = item.in_month;
                    y = item.in_year;
                end
                else
                begin
                    d   = 1;
                    m   = 1;
                    y   = 1;
                    err = 1'b1;
                end
            end
            MODE_NEXT:
            begin
                if (d < days_in_month(m, y))
                    d = d + 1;
                else if (m < 12)
                begin
                    d = 1;
                    m = m + 1;
                end
                else if (y < MAX_YEAR)
                begin
                    d = 1;
                    m = 1;
                    y = y + 1;
                end
                else
                    err = 1'b1;
            end
            MODE_PREV:
            begin
                if (d > 1)
                    d = d - 1;
                else if (m > 1)
                begin
                    m = m - 1;
                    d = days_in_month(m, y);
                end
                else if (y > 1)
                begin
                    y = y - 1;
                    m = 12;
                    d = 31;
                end
                else
                    err = 1'b1;
            end
            MODE_ADD:
            begin
                d = d + (int'(item.add_count) & ((1 << ADD_WIDTH) - 1));
                forever
                begin
                    len = days_in_month(m, y);
                    if (d <= len)
                        break;
                    d = d - len;
                    if (m < 12)
                        m = m + 1;
                    else if (y < MAX_YEAR)
                    begin
                        m = 1;
                        y = y + 1;
                    end
                    else
                    begin
                        err = 1'b1;
                        break;
                    end
                end
                if (err)
                begin
                    d = cal_day;
                    m = cal_month;
                    y = cal_year;
                end
            end
            default: ;
        endcase
        cal_day       = d;
        cal_month     = m;
        cal_year      = y;
        res.cur_day   = 5'(d);
        res.cur_month = 4'(m);
        res.cur_year  = 14'(y);
        res.weekday   = 3'(day_of_week(d, m, y));
        res.error     = err;
        pending_dates.push_back(res);
    endfunction

    // one request transfer; valid is left high so a following request can go straight on
    task automatic send_item(input cds_req_t item);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        advance_date(item);
    endtask

    task automatic send_load(input int d, input int m, input int y);
        cds_req_t item;
        item.mode      = MODE_LOAD;
        item.in_day    = 5'(d);
        item.in_month  = 4'(m);
        item.in_year   = 14'(y);
        item.add_count = 16'($urandom);
        send_item(item);
    endtask

    task automatic send_step(input logic [1:0] mode, input int count);
        cds_req_t item;
        item.mode      = mode;
        item.in_day    = 5'($urandom);
        item.in_month  = 4'($urandom);
        item.in_year   = 14'($urandom);
        item.add_count = (mode == MODE_ADD) ? 16'(count) : 16'($urandom);
        send_item(item);
    endtask

    // drop valid and hold off until every outstanding response is back
    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string label, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    task automatic test_reset_state();
        // stepping back from 1/1/1 holds the date and flags it
        send_step(MODE_PREV, 0);
        send_step(MODE_NEXT, 0);
    endtask

    task automatic test_invalid_loads();
        send_load(0, 5, 2020);
        send_load(31, 4, 2021);
        send_load(29, 2, 1900);
        send_load(15, 0, 2021);
        send_load(31, 15, 16383);
        send_load(15, 6, 0);
        send_load(1, 1, MAX_YEAR + 1);
    endtask

    task automatic test_leap_rules();
        send_load(29, 2, 2000);
        send_load(29, 2, 2024);
        send_step(MODE_NEXT, 0);
        send_step(MODE_PREV, 0);
        send_load(1, 3, 2001);
        send_step(MODE_PREV, 0);
        send_load(1, 1, 2000);
        send_step(MODE_PREV, 0);
    endtask

    task automatic test_year_limits();
        send_load(31, 12, MAX_YEAR);
        send_step(MODE_NEXT, 0);
        send_step(MODE_ADD, 0);
        send_step(MODE_ADD, 1);
        send_load(1, 12, MAX_YEAR);
        send_step(MODE_ADD, 40);
        send_step(MODE_ADD, 30);
        send_load(1, 1, 1);
        send_step(MODE_ADD, 65535);
    endtask

    task automatic test_random(input int count, input int s_idle, input int r_idle);
        int       pick;
        int       d;
        int       m;
        int       y;
        cds_req_t item;
        send_idle = s_idle;
        recv_idle = r_idle;
        repeat (count)
        begin
            item.in_day    = 5'($urandom);
            item.in_month  = 4'($urandom);
            item.in_year   = 14'($urandom);
            item.add_count = 16'($urandom);
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                item.mode = MODE_LOAD;
                pick = $urandom_range(99);
                if (pick < 20)
                begin
                    // close to either end of the year range
                    if ($urandom_range(1) == 1)
                    begin
                        y = MAX_YEAR - $urandom_range(1, 0);
                        m = 12;
                        d = $urandom_range(31, 25);
                    end
                    else
                    begin
                        y = $urandom_range(2, 1);
                        m = 1;
                        d = $urandom_range(5, 1);
                    end
                    item.in_day   = 5'(d);
                    item.in_month = 4'(m);
                    item.in_year  = 14'(y);
                end
                else if (pick >= 30)
                begin
                    // well-formed date, month ends favoured
                    y = $urandom_range(MAX_YEAR, 1);
                    m = $urandom_range(12, 1);
                    d = ($urandom_range(2) == 0) ? days_in_month(m, y)
                                                 : $urandom_range(days_in_month(m, y), 1);
                    item.in_day   = 5'(d);
                    item.in_month = 4'(m);
                    item.in_year  = 14'(y);
                end
            end
            else if (pick < 55)
                item.mode = MODE_NEXT;
            else if (pick < 80)
                item.mode = MODE_PREV;
            else
            begin
                item.mode = MODE_ADD;
                pick = $urandom_range(99);
                // long adds walk many months, so only a few use the full count
                if (pick < 80)
                    item.add_count = 16'($urandom_range(400));
                else if (pick < 95)
                    item.add_count = 16'($urandom_range(3000));
                else
                    item.add_count = 16'($urandom_range(65535));
            end
            send_item(item);
        end
    endtask

    always @(negedge clk)
        rsp_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        cds_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_dates.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none actual %p", $time, rsp);
                mismatches++;
            end
            else
            begin
                want = pending_dates.pop_front();
                check_field("cur_day", want.cur_day, rsp.cur_day);
                check_field("cur_month", want.cur_month, rsp.cur_month);
                check_field("cur_year", want.cur_year, rsp.cur_year);
                check_field("weekday", want.weekday, rsp.weekday);
                check_field("error", want.error, rsp.error);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_ready = 1'b0;
        cal_day   = 1;
        cal_month = 1;
        cal_year  = 1;
        send_idle = 25;
        recv_idle = 47;
        repeat (6)
            @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_invalid_loads();
        test_leap_rules();
        test_year_limits();
        wait_drained();
        test_random(350, 25, 47);
        wait_drained();
        test_random(350, 47, 25);
        wait_drained();
        test_random(300, 0, 0);
        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
